### rtl/core/char_lcd_nibble_sequencer_defines.svh
// Assertion macros used by the checker file clns_checker.sv.
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_DEFINES_SVH

// The consequent holds in the same cycle as the antecedent.
`define CLNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define CLNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/clns_pkg.sv
`default_nettype none

package clns_pkg;

    localparam int CfgIdxW  = 8;
    localparam int CfgDataW = 16;

    localparam logic [CfgIdxW-1:0] REG_BYTE_GAP  = 8'd0;
    localparam logic [CfgIdxW-1:0] REG_INIT_GAP  = 8'd1;
    localparam logic [CfgIdxW-1:0] REG_NUM_ROWS  = 8'd2;
    localparam logic [CfgIdxW-1:0] REG_NUM_COLS  = 8'd3;
    localparam logic [CfgIdxW-1:0] REG_ROW0_BASE = 8'd4;
    localparam logic [CfgIdxW-1:0] REG_ROW1_BASE = 8'd5;
    localparam logic [CfgIdxW-1:0] REG_ROW2_BASE = 8'd6;
    localparam logic [CfgIdxW-1:0] REG_ROW3_BASE = 8'd7;

    localparam logic [1:0] OP_CMD    = 2'd0;
    localparam logic [1:0] OP_DATA   = 2'd1;
    localparam logic [1:0] OP_CURSOR = 2'd2;
    localparam logic [1:0] OP_INIT   = 2'd3;

    localparam int INIT_LEN  = 8;
    localparam int INIT_NIBS = 18;
    localparam int BYTE_NIBS = 2;
    localparam int StepW     = 5;

    localparam logic [7:0] CURSOR_SET = 8'h80;

    localparam int QDepth = 4;
    localparam int QPtrW  = 2;

    typedef struct packed {
        logic [15:0]     byte_gap_us;
        logic [15:0]     init_gap_us;
        logic [2:0]      num_rows;
        logic [5:0]      num_cols;
        logic [3:0][6:0] row_base;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        byte_gap_us: 16'd100,
        init_gap_us: 16'd8000,
        num_rows:    3'd2,
        num_cols:    6'd16,
        row_base:    {7'd84, 7'd20, 7'd64, 7'd0}
    };

    typedef struct packed {
        logic       init;
        logic       rs;
        logic [7:0] code;
    } t_job;

    function automatic logic [7:0] init_code(input logic [2:0] idx);
        logic [7:0] c;
        case (idx)
            3'd0:    c = 8'h30;
            3'd1:    c = 8'h30;
            3'd2:    c = 8'h30;
            3'd3:    c = 8'h20;
            3'd4:    c = 8'h28;
            3'd5:    c = 8'h0E;
            3'd6:    c = 8'h01;
            default: c = 8'h06;
        endcase
        return c;
    endfunction

endpackage

`default_nettype wire

### rtl/core/clns_in_if.sv
`default_nettype none

interface clns_in_if;
    logic       valid;
    logic       ready;
    logic [1:0] cmd;
    logic [7:0] value;
    logic [7:0] row;
    logic [7:0] col;

    modport source (output valid, cmd, value, row, col, input ready);
    modport sink (input valid, cmd, value, row, col, output ready);
    modport monitor (input valid, ready, cmd, value, row, col);
endinterface

`default_nettype wire

### rtl/core/clns_out_if.sv
`default_nettype none

interface clns_out_if;
    logic        valid;
    logic        ready;
    logic        reg_select;
    logic [3:0]  nibble;
    logic [16:0] delay_before_us;
    logic        last;

    modport source (output valid, reg_select, nibble, delay_before_us, last, input ready);
    modport sink (input valid, reg_select, nibble, delay_before_us, last, output ready);
    modport monitor (input valid, ready, reg_select, nibble, delay_before_us, last);
endinterface

`default_nettype wire

### rtl/core/clns_cfg_if.sv
`default_nettype none

interface clns_cfg_if import clns_pkg::*;;
    logic                valid;
    logic                ready;
    logic [CfgIdxW-1:0]  index;
    logic [CfgDataW-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

### rtl/core/clns_front.sv
`default_nettype none

module clns_front
    import clns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    clns_in_if.sink   i_in,
    input  wire logic i_full,
    output logic      o_push,
    output t_job      o_job
);

    localparam logic [1:0] F_ACCEPT = 2'd0;
    localparam logic [1:0] F_DIV    = 2'd1;
    localparam logic [1:0] F_PUSH   = 2'd2;

    logic [1:0] r_state, n_state;
    logic [2:0] r_cnt, n_cnt;
    logic [7:0] r_row_sh, n_row_sh;
    logic [7:0] r_col_sh, n_col_sh;
    logic [2:0] r_row_rem, n_row_rem;
    logic [5:0] r_col_rem, n_col_rem;

    logic [2:0] nr;
    logic [5:0] nc;
    logic [3:0] row_t;
    logic [6:0] col_t;
    logic [2:0] row_step;
    logic [5:0] col_step;
    logic       accept;

    function automatic logic [7:0] cursor_code(input t_cfg cfg, input logic [2:0] r,
                                               input logic [5:0] c);
        logic [6:0] base;
        case (r)
            3'd1:    base = cfg.row_base[1];
            3'd2:    base = cfg.row_base[2];
            3'd3:    base = cfg.row_base[3];
            default: base = cfg.row_base[0];
        endcase
        return (CURSOR_SET | {1'b0, base}) + {2'b00, c};
    endfunction

    assign nr = (i_cfg.num_rows == 3'd0) ? 3'd1 : i_cfg.num_rows;
    assign nc = (i_cfg.num_cols == 6'd0) ? 6'd1 : i_cfg.num_cols;

    assign row_t    = {r_row_rem, r_row_sh[7]};
    assign col_t    = {r_col_rem, r_col_sh[7]};
    assign row_step = (row_t >= {1'b0, nr}) ? 3'(row_t - {1'b0, nr}) : row_t[2:0];
    assign col_step = (col_t >= {1'b0, nc}) ? 6'(col_t - {1'b0, nc}) : col_t[5:0];

    assign i_in.ready = (r_state == F_ACCEPT) && !i_full;
    assign accept     = i_in.valid && i_in.ready;

    always_comb begin
        n_state   = r_state;
        n_cnt     = r_cnt;
        n_row_sh  = r_row_sh;
        n_col_sh  = r_col_sh;
        n_row_rem = r_row_rem;
        n_col_rem = r_col_rem;
        o_push    = 1'b0;
        o_job     = '{init: 1'b0, rs: 1'b0, code: i_in.value};
        case (r_state)
            F_ACCEPT: begin
                if (accept) begin
                    if (i_in.cmd == OP_CURSOR) begin
                        n_state   = F_DIV;
                        n_cnt     = 3'd0;
                        n_row_sh  = i_in.row;
                        n_col_sh  = i_in.col;
                        n_row_rem = 3'd0;
                        n_col_rem = 6'd0;
                    end else begin
                        o_push     = 1'b1;
                        o_job.init = (i_in.cmd == OP_INIT);
                        o_job.rs   = (i_in.cmd == OP_DATA);
                        if (i_in.cmd == OP_INIT) begin
                            o_job.code = cursor_code(i_cfg, 3'd0, 6'd0);
                        end
                    end
                end
            end
            F_DIV: begin
                n_row_rem = row_step;
                n_col_rem = col_step;
                n_row_sh  = {r_row_sh[6:0], 1'b0};
                n_col_sh  = {r_col_sh[6:0], 1'b0};
                n_cnt     = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_state = F_PUSH;
                end
            end
            F_PUSH: begin
                o_job.code = cursor_code(i_cfg, r_row_rem, r_col_rem);
                if (!i_full) begin
                    o_push  = 1'b1;
                    n_state = F_ACCEPT;
                end
            end
            default: begin
                n_state = F_ACCEPT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= F_ACCEPT;
            r_cnt   <= 3'd0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
        r_row_sh  <= n_row_sh;
        r_col_sh  <= n_col_sh;
        r_row_rem <= n_row_rem;
        r_col_rem <= n_col_rem;
    end

endmodule

`default_nettype wire

### rtl/core/clns_queue.sv
`default_nettype none

module clns_queue
    import clns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job             r_mem [QDepth];
    logic [QPtrW-1:0] r_wr_ptr;
    logic [QPtrW-1:0] r_rd_ptr;
    logic [QPtrW:0]   r_count;

    assign o_full  = (r_count == (QPtrW + 1)'(QDepth));
    assign o_valid = (r_count != '0);
    assign o_job   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

endmodule

`default_nettype wire

### rtl/core/clns_back.sv
`default_nettype none

module clns_back
    import clns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_cfg i_cfg,
    input  wire logic i_valid,
    input  wire t_job i_job,
    output logic      o_pop,
    clns_out_if.source o_out
);

    logic [StepW-1:0] r_step;
    logic             r_out_valid;
    logic             r_rs;
    logic [3:0]       r_nib;
    logic [16:0]      r_delay;
    logic             r_last;

    logic             load;
    logic [3:0]       byte_idx;
    logic             in_table;
    logic [7:0]       code;
    logic             high;
    logic [16:0]      gap_sum;
    logic             last_nib;

    assign load     = i_valid && (!r_out_valid || o_out.ready);
    assign byte_idx = r_step[StepW-1:1];
    assign in_table = i_job.init && (byte_idx < 4'(INIT_LEN));
    assign code     = in_table ? init_code(byte_idx[2:0]) : i_job.code;
    assign high     = !r_step[0];
    assign gap_sum  = {1'b0, i_cfg.byte_gap_us}
                    + (in_table ? {1'b0, i_cfg.init_gap_us} : 17'd0);
    assign last_nib = (r_step == (i_job.init ? StepW'(INIT_NIBS - 1)
                                             : StepW'(BYTE_NIBS - 1)));
    assign o_pop    = load && last_nib;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (load) begin
                r_step      <= last_nib ? '0 : r_step + 1'b1;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (load) begin
            r_rs    <= i_job.rs;
            r_nib   <= high ? code[7:4] : code[3:0];
            r_delay <= high ? gap_sum : 17'd0;
            r_last  <= last_nib;
        end
    end

    assign o_out.valid           = r_out_valid;
    assign o_out.reg_select      = r_rs;
    assign o_out.nibble          = r_nib;
    assign o_out.delay_before_us = r_delay;
    assign o_out.last            = r_last;

endmodule

`default_nettype wire

### rtl/core/char_lcd_nibble_sequencer.sv
// Character LCD nibble sequencer for a 4-bit bus.
// The input channel i_in takes one operation per beat: command byte, data byte,
// cursor move or power-up init. The output channel o_out gives one beat per
// nibble to drive: RS, the four data bits, the microseconds to wait first, and
// a last flag on the final nibble of the operation. Byte operations give two
// beats, init gives eighteen.
// The configuration channel i_cfg writes gaps, geometry and row bases; it is
// always ready. It must be written only while the block is idle; the block
// itself does not enforce this. An accepted item goes through the queue to the
// back end's output register; a cursor move first has its row and column
// wrapped in the front end, one remainder bit a cycle, and the front end takes
// no new item until it has pushed the cursor move into the queue. The back end
// then gives one nibble per cycle while the receiver is ready.
// A four-entry queue between the front and back ends lets items be accepted
// while earlier ones are still being sent. When the receiver stalls, the output
// beat holds and the queue fills; the input stalls once the queue is full.
// Synchronous reset empties the queue and output and restores the register
// defaults.
`default_nettype none

module char_lcd_nibble_sequencer
    import clns_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    clns_in_if.sink   i_in,
    clns_out_if.source o_out,
    clns_cfg_if.sink  i_cfg
);

    t_cfg r_cfg;
    logic q_push;
    t_job q_in_job;
    logic q_full;
    logic q_pop;
    logic q_valid;
    t_job q_out_job;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                REG_BYTE_GAP:  r_cfg.byte_gap_us <= i_cfg.data;
                REG_INIT_GAP:  r_cfg.init_gap_us <= i_cfg.data;
                REG_NUM_ROWS:  r_cfg.num_rows    <= i_cfg.data[2:0];
                REG_NUM_COLS:  r_cfg.num_cols    <= i_cfg.data[5:0];
                REG_ROW0_BASE: r_cfg.row_base[0] <= i_cfg.data[6:0];
                REG_ROW1_BASE: r_cfg.row_base[1] <= i_cfg.data[6:0];
                REG_ROW2_BASE: r_cfg.row_base[2] <= i_cfg.data[6:0];
                REG_ROW3_BASE: r_cfg.row_base[3] <= i_cfg.data[6:0];
                default: begin
                end
            endcase
        end
    end

    clns_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_in    (i_in),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_job   (q_in_job)
    );

    clns_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (q_in_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_out_job)
    );

    clns_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (q_valid),
        .i_job   (q_out_job),
        .o_pop   (q_pop),
        .o_out   (o_out)
    );

endmodule

`default_nettype wire

### rtl/core/clns_checker.sv
`default_nettype none
`include "char_lcd_nibble_sequencer_defines.svh"

module clns_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        i_ready,
    input wire logic        i_reg_select,
    input wire logic [3:0]  i_nibble,
    input wire logic [16:0] i_delay_before_us,
    input wire logic        i_last
);

    logic out_acc;
    logic r_odd;
    logic r_first_rs;

    assign out_acc = i_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_odd <= 1'b0;
        end else if (out_acc) begin
            r_odd <= !r_odd;
        end
        if (out_acc) begin
            r_first_rs <= i_reg_select;
        end
    end

    `CLNS_ASSERT_NOW(a_last_on_low_nibble, out_acc && i_last, r_odd, "last flag on a high nibble")
    `CLNS_ASSERT_NOW(a_low_nibble_no_wait, out_acc && r_odd, i_delay_before_us == 17'd0, "low nibble with a wait")
    `CLNS_ASSERT_NOW(a_rs_steady_in_byte, out_acc && r_odd, i_reg_select == r_first_rs, "RS changed within a byte")
    `CLNS_ASSERT_NEXT(a_hold_on_stall, i_valid && !i_ready, i_valid && $stable(i_nibble) && $stable(i_delay_before_us), "output beat changed while stalled")

endmodule

bind char_lcd_nibble_sequencer clns_checker u_clns_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_valid           (o_out.valid),
    .i_ready           (o_out.ready),
    .i_reg_select      (o_out.reg_select),
    .i_nibble          (o_out.nibble),
    .i_delay_before_us (o_out.delay_before_us),
    .i_last            (o_out.last)
);

`default_nettype wire
